// ===== sv/lib_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lib_pkg: shared types for the live interval builder
// Request and response transfer structs, function and result codes, and the
// flag bundle returned by the drain search.
// ----------------------------------------------------------------------------
package lib_pkg;

   localparam int REG_BITS   = 8;   // virtual register number width
   localparam int FIELD_BITS = 16;  // width of returned instruction indices

   typedef enum logic [1:0] {
      FUNC_PARAM = 2'b00,
      FUNC_INST  = 2'b01,
      FUNC_DRAIN = 2'b10,
      FUNC_CLEAR = 2'b11
   } func_type;

   typedef enum logic [1:0] {
      KIND_ACK      = 2'd0,
      KIND_INTERVAL = 2'd1,
      KIND_DONE     = 2'd2
   } kind_type;

   typedef struct packed {
      func_type              func;
      logic                  dest_valid;
      logic [REG_BITS-1:0]   dest_reg;
      logic                  src1_valid;
      logic [REG_BITS-1:0]   src1_reg;
      logic                  src2_valid;
      logic [REG_BITS-1:0]   src2_reg;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [REG_BITS-1:0]   out_reg;
      logic [FIELD_BITS-1:0] start_index;
      logic [FIELD_BITS-1:0] end_index;
      logic                  undefined_use;
      logic                  index_overflow;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic found;  // a live entry at or above the cursor
      logic last;   // nothing live above the one found
   } find_flags_type;

endpackage

// ===== sv/lib_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lib_find: next live entry search
// Finds the lowest set valid bit at or above the cursor and reports whether
// it is the final one.
// ----------------------------------------------------------------------------
module lib_find #(
   parameter int DEPTH = 256
) (
   input  logic [DEPTH-1:0]              valid,
   input  logic [$clog2(DEPTH+1)-1:0]    cursor,
   output logic [$clog2(DEPTH)-1:0]      idx,
   output lib_pkg::find_flags_type       flags
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [DEPTH-1:0] cand;
   logic [DEPTH-1:0] lowest;
   logic [DEPTH-1:0] rest;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cand[i] = valid[i] && (CW'(i) >= cursor);
      end
   end

   // isolate lowest set bit; clearing it leaves the ones above
   assign lowest = cand & (~cand + DEPTH'(1));
   assign rest   = cand & (cand - DEPTH'(1));

   always_comb begin
      idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (lowest[i]) begin
            idx = idx | AW'(i);
         end
      end
   end

   assign flags.found = |cand;
   assign flags.last  = (rest == '0);

endmodule

// ===== sv/live_interval_builder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// live_interval_builder_core: live interval table for linear-scan allocation
// Tracks [start, end] instruction indices per virtual register and drains
// the live intervals in ascending register order.
// ----------------------------------------------------------------------------
// One item per cycle while the result side does not stall: each accepted
// transfer passes through the input register and the table update/read
// stage and lands in the response register, from which its result is
// offered. The rate is set by the table stage, where a parameter or
// instruction performs all its writes (start, and up to two last-use entries)
// and a drain finds its next live entry and reads it, both in that stage. Ends
// are kept in three banks (definition, first source, second source) so each
// bank takes one write per cycle; the end returned is the largest live bank
// value, which is exact because indices only grow within one interval. Per
// register valid bits live in flip-flops, so reset and clear take effect at
// once with no sweep of the table. Only register numbers below
// min(NUM_VREGS, 256) are stored; others are ignored as destinations and
// reported as undefined uses. Up to two transfers are held while the result
// side stalls before req_stall is raised.
// ----------------------------------------------------------------------------
module live_interval_builder_core #(
   parameter int NUM_VREGS  = 256,
   parameter int INDEX_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lib_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lib_pkg::rsp_type  rsp_item
);

   // register numbers are 8 bits, so no more than 256 entries can be reached
   localparam int REG_SPAN = 2 ** lib_pkg::REG_BITS;
   localparam int DEPTH    = (NUM_VREGS < REG_SPAN) ? NUM_VREGS : REG_SPAN;
   localparam int AW       = $clog2(DEPTH);
   localparam int CW       = $clog2(DEPTH + 1);
   localparam logic [lib_pkg::REG_BITS:0] DEPTH_W = (lib_pkg::REG_BITS + 1)'(DEPTH);

   // ---- input register -----------------------------------------------------
   logic             a_valid_ff;
   lib_pkg::req_type a_item_ff;

   // ---- table stage output -------------------------------------------------
   logic                  b_valid_ff;
   lib_pkg::kind_type     b_kind_ff;
   logic [AW-1:0]         b_reg_ff;
   logic                  b_undef_ff;
   logic                  b_ovf_ff;
   logic                  b_last_ff;
   logic                  b_u1_ff;
   logic                  b_u2_ff;
   logic [INDEX_BITS-1:0] start_rd_ff;
   logic [INDEX_BITS-1:0] use1_rd_ff;
   logic [INDEX_BITS-1:0] use2_rd_ff;

   // ---- response register --------------------------------------------------
   logic             rsp_valid_ff;
   lib_pkg::rsp_type rsp_item_ff;
   lib_pkg::rsp_type rsp_item_in;

   // ---- table state --------------------------------------------------------
   logic [DEPTH-1:0]      valid_ff, valid_in;
   logic [DEPTH-1:0]      u1_live_ff, u1_live_in;  // first-source bank holds an end
   logic [DEPTH-1:0]      u2_live_ff, u2_live_in;  // second-source bank holds an end
   logic [INDEX_BITS-1:0] counter_ff, counter_in;
   logic [CW-1:0]         cursor_ff, cursor_in;

   logic [INDEX_BITS-1:0] start_mem [DEPTH];
   logic [INDEX_BITS-1:0] use1_mem  [DEPTH];
   logic [INDEX_BITS-1:0] use2_mem  [DEPTH];

   // ---- handshake ----------------------------------------------------------
   logic move_bo;  // table stage hands on to the response register
   logic move_ab;  // input register enters the table stage

   assign move_bo   = b_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign move_ab   = a_valid_ff && (!b_valid_ff || move_bo);
   assign req_stall = a_valid_ff && !move_ab;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         a_item_ff <= req_item;
      end
   end

   // ---- decode of the held transfer ----------------------------------------
   logic [AW-1:0] dest_idx, s1_idx, s2_idx;
   logic          dest_in, s1_in, s2_in;
   logic          is_param, is_inst, is_drain, is_clear;
   logic          sat;
   logic [INDEX_BITS-1:0] at;
   logic          create, define;
   logic          s1_ok, s2_ok, s1_wr, s2_wr, undef;

   logic [AW-1:0]               find_idx;
   lib_pkg::find_flags_type     find_flags;

   assign dest_idx = a_item_ff.dest_reg[AW-1:0];
   assign s1_idx   = a_item_ff.src1_reg[AW-1:0];
   assign s2_idx   = a_item_ff.src2_reg[AW-1:0];
   assign dest_in  = {1'b0, a_item_ff.dest_reg} < DEPTH_W;
   assign s1_in    = {1'b0, a_item_ff.src1_reg} < DEPTH_W;
   assign s2_in    = {1'b0, a_item_ff.src2_reg} < DEPTH_W;

   always_comb begin
      is_param = 1'b0;
      is_inst  = 1'b0;
      is_drain = 1'b0;
      is_clear = 1'b0;
      unique case (a_item_ff.func)
         lib_pkg::FUNC_PARAM: is_param = 1'b1;
         lib_pkg::FUNC_INST:  is_inst  = 1'b1;
         lib_pkg::FUNC_DRAIN: is_drain = 1'b1;
         lib_pkg::FUNC_CLEAR: is_clear = 1'b1;
         default:             is_clear = 1'b0;
      endcase
   end

   // counter saturates at all ones; an instruction's index is the new count
   assign sat = &counter_ff;
   assign at  = sat ? counter_ff : counter_ff + INDEX_BITS'(1);

   assign create = is_inst && a_item_ff.dest_valid && dest_in && !valid_ff[dest_idx];
   assign define = (is_param && a_item_ff.dest_valid && dest_in) || create;

   // a source equal to a freshly created destination finds it
   assign s1_ok = s1_in && (valid_ff[s1_idx] || (create && s1_idx == dest_idx));
   assign s2_ok = s2_in && (valid_ff[s2_idx] || (create && s2_idx == dest_idx));
   assign s1_wr = is_inst && a_item_ff.src1_valid && s1_ok;
   assign s2_wr = is_inst && a_item_ff.src2_valid && s2_ok;
   assign undef = (a_item_ff.src1_valid && !s1_ok) || (a_item_ff.src2_valid && !s2_ok);

   lib_find #(
      .DEPTH (DEPTH)
   ) u_find (
      .valid  (valid_ff),
      .cursor (cursor_ff),
      .idx    (find_idx),
      .flags  (find_flags)
   );

   // ---- table state next values --------------------------------------------
   always_comb begin
      valid_in   = valid_ff;
      u1_live_in = u1_live_ff;
      u2_live_in = u2_live_ff;
      counter_in = counter_ff;
      cursor_in  = cursor_ff;
      if (move_ab) begin
         if (is_clear) begin
            valid_in   = '0;
            u1_live_in = '0;
            u2_live_in = '0;
            counter_in = '0;
            cursor_in  = '0;
         end else begin
            if (is_inst) begin
               counter_in = at;
            end
            // a new interval starts with no source ends
            if (define) begin
               valid_in[dest_idx]   = 1'b1;
               u1_live_in[dest_idx] = 1'b0;
               u2_live_in[dest_idx] = 1'b0;
            end
            if (s1_wr) begin
               u1_live_in[s1_idx] = 1'b1;
            end
            if (s2_wr) begin
               u2_live_in[s2_idx] = 1'b1;
            end
            if (is_drain) begin
               cursor_in = find_flags.found ? CW'(find_idx) + CW'(1) : CW'(DEPTH);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         u1_live_ff <= '0;
         u2_live_ff <= '0;
         counter_ff <= '0;
         cursor_ff  <= '0;
      end else begin
         valid_ff   <= valid_in;
         u1_live_ff <= u1_live_in;
         u2_live_ff <= u2_live_in;
         counter_ff <= counter_in;
         cursor_ff  <= cursor_in;
      end
   end

   // ---- interval banks -----------------------------------------------------
   always_ff @(posedge clock) begin
      if (move_ab && define) begin
         start_mem[dest_idx] <= is_param ? '0 : at;
      end
      if (move_ab) begin
         start_rd_ff <= start_mem[find_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (move_ab && s1_wr) begin
         use1_mem[s1_idx] <= at;
      end
      if (move_ab) begin
         use1_rd_ff <= use1_mem[find_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (move_ab && s2_wr) begin
         use2_mem[s2_idx] <= at;
      end
      if (move_ab) begin
         use2_rd_ff <= use2_mem[find_idx];
      end
   end

   // ---- table stage register -----------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (move_ab) begin
         b_valid_ff <= 1'b1;
      end else if (move_bo) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move_ab) begin
         if (is_drain) begin
            b_kind_ff <= find_flags.found ? lib_pkg::KIND_INTERVAL : lib_pkg::KIND_DONE;
         end else begin
            b_kind_ff <= lib_pkg::KIND_ACK;
         end
         b_reg_ff   <= find_idx;
         b_undef_ff <= is_inst && undef;
         b_ovf_ff   <= is_inst && sat;
         b_last_ff  <= find_flags.last;
         b_u1_ff    <= u1_live_ff[find_idx];
         b_u2_ff    <= u2_live_ff[find_idx];
      end
   end

   // ---- response: end is the largest live bank value -----------------------
   logic [INDEX_BITS-1:0] end_a, end_full;

   always_comb begin
      end_a    = (b_u1_ff && use1_rd_ff > start_rd_ff) ? use1_rd_ff : start_rd_ff;
      end_full = (b_u2_ff && use2_rd_ff > end_a) ? use2_rd_ff : end_a;
   end

   always_comb begin
      rsp_item_in                = '0;
      rsp_item_in.kind           = b_kind_ff;
      rsp_item_in.undefined_use  = b_undef_ff;
      rsp_item_in.index_overflow = b_ovf_ff;
      if (b_kind_ff == lib_pkg::KIND_INTERVAL) begin
         rsp_item_in.out_reg     = lib_pkg::REG_BITS'(b_reg_ff);
         rsp_item_in.start_index = lib_pkg::FIELD_BITS'(start_rd_ff);
         rsp_item_in.end_index   = lib_pkg::FIELD_BITS'(end_full);
         rsp_item_in.last        = b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move_bo) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move_bo) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---- assertions ---------------------------------------------------------
   // source banks only ever hold ends for registers that are live
   a_live_subset: assert property (@(posedge clock) disable iff (reset)
      ((u1_live_ff | u2_live_ff) & ~valid_ff) == '0)
      else $error("source end held for a register with no interval");

   // clear empties the table in the same transfer
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      move_ab && is_clear |=> valid_ff == '0 && counter_ff == '0 && cursor_ff == '0)
      else $error("clear left table state behind");

   // a drain that finds nothing parks the cursor at the end
   a_drain_parks: assert property (@(posedge clock) disable iff (reset)
      move_ab && is_drain && !find_flags.found |=> cursor_ff == CW'(DEPTH))
      else $error("empty drain did not park the cursor");

   // an emitted interval never ends before it starts
   a_interval_order: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_kind_ff == lib_pkg::KIND_INTERVAL |-> end_full >= start_rd_ff)
      else $error("interval end below its start");

endmodule
